// ===== rtl/text_console_line_editor_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_line_editor_assert.svh
// Assertion macros used by the line editor checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_LINE_EDITOR_ASSERT_SVH
`define TEXT_CONSOLE_LINE_EDITOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TCLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TCLE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcle_pkg.sv =====
// ----------------------------------------------------------------------------
// tcle_pkg
// Shared constants and types of the text console line editor.
// ----------------------------------------------------------------------------
package tcle_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int IDX_W  = 11;   // cell_index / cursor_pos port width
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;

	localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] BLANK_CHAR    = 8'd32;
	localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'h07;

	// register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_TEXT_ATTR = 1'b0;  // register index, paddr[2]

	typedef enum logic {
		KIND_CELL   = 1'b0,
		KIND_CURSOR = 1'b1
	} result_kind_t;

	// results produced by one key press
	typedef struct packed {
		logic              has_cell;
		logic [IDX_W-1:0]  cell_index;
		logic [CHAR_W-1:0] cell_char;
		logic [IDX_W-1:0]  cursor_pos;
	} edit_out_t;

endpackage

// ===== rtl/tcle_fill_store.sv =====
// ----------------------------------------------------------------------------
// tcle_fill_store
// Per-row fill counts: one write port, one read port, cleared by reset.
// ----------------------------------------------------------------------------
module tcle_fill_store import tcle_pkg::*; #(
	parameter int ROWS   = ROWS_DEF,
	parameter int FILL_W = $clog2(COLUMNS_DEF + 1),
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ROW_W-1:0]  wr_addr,
	input  logic [FILL_W-1:0] wr_data,
	input  logic [ROW_W-1:0]  rd_addr,
	output logic [FILL_W-1:0] rd_data
);

	logic [FILL_W-1:0] fill_q [ROWS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (wr_en) begin
			fill_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = fill_q[rd_addr];

endmodule

// ===== rtl/tcle_edit_core.sv =====
// ----------------------------------------------------------------------------
// tcle_edit_core
// Next row / fill and the results of one key press.
// ----------------------------------------------------------------------------
module tcle_edit_core import tcle_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int FILL_W = $clog2(COLUMNS + 1)
) (
	input  logic [CHAR_W-1:0] key_char,
	input  logic [ROW_W-1:0]  row,
	input  logic [FILL_W-1:0] fill,
	input  logic [FILL_W-1:0] prev_fill,   // fill of row - 1
	output logic [ROW_W-1:0]  nxt_row,
	output logic [FILL_W-1:0] nxt_fill,
	output edit_out_t         eo
);

	localparam int PROD_W = $clog2(ROWS * COLUMNS + 1);
	localparam int POS_W  = (PROD_W > IDX_W) ? PROD_W : IDX_W;

	logic              last_row;
	logic              full;
	logic [ROW_W-1:0]  row_inc;
	logic [FILL_W-1:0] cell_col;
	logic [CHAR_W-1:0] cell_char;
	logic              has_cell;
	logic [POS_W-1:0]  base;
	logic [POS_W-1:0]  cell_pos;
	logic [POS_W-1:0]  end_pos;
	logic [POS_W-1:0]  cur_pos;

	assign last_row = (row == ROW_W'(ROWS - 1));
	assign full     = (fill >= FILL_W'(COLUMNS));
	assign row_inc  = last_row ? row : ROW_W'(row + 1'b1);

	always_comb begin
		nxt_row   = row;
		nxt_fill  = fill;
		has_cell  = 1'b0;
		cell_col  = fill;
		cell_char = key_char;
		case (key_char)
			KEY_NEWLINE: begin
				nxt_row  = row_inc;
				nxt_fill = '0;
			end
			KEY_BACKSPACE: begin
				if (fill != '0) begin
					nxt_fill  = FILL_W'(fill - 1'b1);
					cell_col  = FILL_W'(fill - 1'b1);
					cell_char = BLANK_CHAR;
					has_cell  = 1'b1;
				end else if (row != '0) begin
					// empty row: step back to end of previous row, no erase
					nxt_row  = ROW_W'(row - 1'b1);
					nxt_fill = prev_fill;
				end
			end
			default: begin
				has_cell = 1'b1;
				if (full) begin
					nxt_row  = row_inc;
					cell_col = '0;
					nxt_fill = FILL_W'(1);
				end else begin
					cell_col = fill;
					nxt_fill = FILL_W'(fill + 1'b1);
				end
			end
		endcase
	end

	assign base     = POS_W'(nxt_row) * POS_W'(COLUMNS);
	assign cell_pos = base + POS_W'(cell_col);
	assign end_pos  = base + POS_W'(nxt_fill);
	assign cur_pos  = (end_pos == '0) ? '0 : POS_W'(end_pos - 1'b1);

	assign eo.has_cell   = has_cell;
	assign eo.cell_index = cell_pos[IDX_W-1:0];
	assign eo.cell_char  = cell_char;
	assign eo.cursor_pos = cur_pos[IDX_W-1:0];

endmodule

// ===== rtl/text_console_line_editor.sv =====
// ----------------------------------------------------------------------------
// text_console_line_editor
// Line editor over a text grid: key items in, cell writes and cursor out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one translated key event per item.
//    Release items are taken and dropped; they produce nothing.
//  - Output channel (out_valid/out_ready): per key press an optional cell
//    write item (result_kind = cell) then one cursor item (last_of_run = 1).
//  - APB port: register 0 at byte address 0 is the attribute byte stamped
//    on every cell write (reset 0x07). Write it only while the block is idle.
//  - Path: an accepted item goes through the input register, then the
//    result buffer, before its first result is on the output.
//  - Rate: one item per cycle for cursor-only keys and releases while the
//    output is ready; keys that also write a cell put two items on the port.
//  - The input register keeps taking items while a finished result waits
//    for out_ready; a stalled output holds its item unchanged and stalls
//    the input only once both stages are full.
//  - Reset clears the row pointer, all row fills and both stages' valids.
// ----------------------------------------------------------------------------
module text_console_line_editor import tcle_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// key items
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAR_W-1:0]     key_char,
	input  logic                  key_released,
	// result items
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  result_kind,
	output logic [IDX_W-1:0]      cell_index,
	output logic [CHAR_W-1:0]     cell_char,
	output logic [ATTR_W-1:0]     cell_attr,
	output logic [IDX_W-1:0]      cursor_pos,
	output logic                  last_of_run,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FILL_W = $clog2(COLUMNS + 1);

	// attribute register
	logic [ATTR_W-1:0] text_attribute_q;

	// input stage (press items only)
	logic              valid_s1;
	logic [CHAR_W-1:0] key_char_s1;

	// editor state; fill_q mirrors the store entry of the current row
	logic [ROW_W-1:0]  row_q;
	logic [FILL_W-1:0] fill_q;

	// result buffer: optional cell write, then cursor
	logic              buf_valid_q;
	logic              has_cell_q;
	logic [IDX_W-1:0]  cell_index_q;
	logic [CHAR_W-1:0] cell_char_q;
	logic [ATTR_W-1:0] cell_attr_q;
	logic [IDX_W-1:0]  cursor_pos_q;

	logic              buf_free;
	logic              advance;
	logic [ROW_W-1:0]  prev_row;
	logic [FILL_W-1:0] prev_fill;
	logic [ROW_W-1:0]  nxt_row;
	logic [FILL_W-1:0] nxt_fill;
	edit_out_t         eo;
	logic              cfg_wr;

	// ---- APB ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= ATTR_RESET;
		end else if (cfg_wr) begin
			text_attribute_q <= pwdata[ATTR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_TEXT_ATTR) ?
		APB_DATA_W'(text_attribute_q) : '0;

	// ---- handshake ----
	// buffer frees when empty, or when its final (cursor) item leaves now
	assign buf_free = !buf_valid_q || (out_ready && !has_cell_q);
	assign advance  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && !key_released;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_char_s1 <= key_char;
		end
	end

	// ---- edit logic ----
	assign prev_row = (row_q == '0) ? '0 : ROW_W'(row_q - 1'b1);

	tcle_fill_store #(
		.ROWS   (ROWS),
		.FILL_W (FILL_W)
	) u_fill (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (advance),
		.wr_addr (nxt_row),
		.wr_data (nxt_fill),
		.rd_addr (prev_row),
		.rd_data (prev_fill)
	);

	tcle_edit_core #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_core (
		.key_char  (key_char_s1),
		.row       (row_q),
		.fill      (fill_q),
		.prev_fill (prev_fill),
		.nxt_row   (nxt_row),
		.nxt_fill  (nxt_fill),
		.eo        (eo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			fill_q <= '0;
		end else if (advance) begin
			row_q  <= nxt_row;
			fill_q <= nxt_fill;
		end
	end

	// ---- result buffer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			has_cell_q  <= 1'b0;
		end else if (advance) begin
			buf_valid_q <= 1'b1;
			has_cell_q  <= eo.has_cell;
		end else if (buf_valid_q && out_ready) begin
			if (has_cell_q) begin
				has_cell_q <= 1'b0;     // cell item gone, cursor next
			end else begin
				buf_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cell_index_q <= eo.cell_index;
			cell_char_q  <= eo.cell_char;
			cell_attr_q  <= text_attribute_q;
			cursor_pos_q <= eo.cursor_pos;
		end
	end

	assign out_valid   = buf_valid_q;
	assign result_kind = has_cell_q ? KIND_CELL : KIND_CURSOR;
	assign cell_index  = has_cell_q ? cell_index_q : '0;
	assign cell_char   = has_cell_q ? cell_char_q : '0;
	assign cell_attr   = has_cell_q ? cell_attr_q : '0;
	assign cursor_pos  = has_cell_q ? '0 : cursor_pos_q;
	assign last_of_run = !has_cell_q;

endmodule

// ===== rtl/tcle_checker.sv =====
// ----------------------------------------------------------------------------
// tcle_checker
// Port-level checks of the line editor's result channel.
// ----------------------------------------------------------------------------
`include "text_console_line_editor_assert.svh"

module tcle_checker import tcle_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  result_kind,
	input logic [IDX_W-1:0]      cell_index,
	input logic [CHAR_W-1:0]     cell_char,
	input logic [ATTR_W-1:0]     cell_attr,
	input logic [IDX_W-1:0]      cursor_pos,
	input logic                  last_of_run
);

	`TCLE_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "result during reset")

	`TCLE_ASSERT(a_cursor_fields, (out_valid && result_kind == KIND_CURSOR) |-> (cell_index == '0 && cell_char == '0 && cell_attr == '0 && last_of_run), "bad cursor item")

	`TCLE_ASSERT(a_cell_fields, (out_valid && result_kind == KIND_CELL) |-> (cursor_pos == '0 && !last_of_run), "bad cell item")

	`TCLE_ASSERT(a_cell_then_cursor, (out_valid && out_ready && result_kind == KIND_CELL) |=> (out_valid && result_kind == KIND_CURSOR), "cell item not followed by cursor")

	`TCLE_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(result_kind) && $stable(cell_index) && $stable(cursor_pos)), "stalled item changed")

endmodule

bind text_console_line_editor tcle_checker u_tcle_checker (.*);

// ===== verif/text_console_line_editor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_line_editor_test
// Self-checking bench for the console line editor: key items go in, every
// cell write and cursor item coming out is compared with an in-bench model
// of the row pointer, the per-row fill counts and the attribute register.
// ----------------------------------------------------------------------------
module text_console_line_editor_test;
	import tcle_pkg::*;

	localparam int COLS  = COLUMNS_DEF;
	localparam int NROWS = ROWS_DEF;

	// register map: register i at byte address 4*i
	localparam logic REG_UNUSED = 1'b1;
	localparam logic [APB_ADDR_W-1:0] ADDR_TEXT_ATTR = {REG_TEXT_ATTR, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED    = {REG_UNUSED, 2'b00};

	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;   // long output stall
	localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all

	// one result item as it shows on the output port
	typedef struct packed {
		result_kind_t      kind;
		logic [IDX_W-1:0]  cell_index;
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attr;
		logic [IDX_W-1:0]  cursor_pos;
		logic              last;
	} screen_update_t;

	logic                  clk = 1'b1;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [CHAR_W-1:0]     key_char;
	logic                  key_released;
	logic                  out_valid;
	logic                  out_ready;
	logic                  result_kind;
	logic [IDX_W-1:0]      cell_index;
	logic [CHAR_W-1:0]     cell_char;
	logic [ATTR_W-1:0]     cell_attr;
	logic [IDX_W-1:0]      cursor_pos;
	logic                  last_of_run;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// screen model: row pointer, fill per row, attribute register
	logic [4:0]        pred_row;
	logic [6:0]        pred_fill [NROWS];
	logic [ATTR_W-1:0] pred_attr;

	screen_update_t updates_due[$];   // oldest first
	int mismatch_count;
	int quiet_cycles;
	int burst_left;       // items left in the current sender burst
	int hold_request;     // set by a test, picked up by the receiver
	int hold_left;
	int ready_pct;
	int pattern_left;

	text_console_line_editor #(
		.COLUMNS(COLS),
		.ROWS(NROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key_char(key_char),
		.key_released(key_released),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.cell_index(cell_index),
		.cell_char(cell_char),
		.cell_attr(cell_attr),
		.cursor_pos(cursor_pos),
		.last_of_run(last_of_run),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b0;
		#6 clk = 1'b1;
	end

	// ------------------------------------------------------------------
	// Screen model
	// ------------------------------------------------------------------

	// Cursor items carry zeros in the cell fields and vice versa; the
	// cursor item always closes the run.
	function automatic void queue_update(input result_kind_t kind, input int idx,
			input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] attr, input int pos);
		screen_update_t u;
		u.kind       = kind;
		u.cell_index = idx[IDX_W-1:0];
		u.cell_char  = ch;
		u.cell_attr  = attr;
		u.cursor_pos = pos[IDX_W-1:0];
		u.last       = (kind == KIND_CURSOR);
		updates_due.push_back(u);
	endfunction

	// Next row, clamped at the bottom; the row it lands on is emptied.
	function automatic void advance_row();
		if (pred_row < NROWS - 1)
			pred_row = pred_row + 1'b1;
		pred_fill[pred_row] = '0;
	endfunction

	function automatic void apply_key(input logic [CHAR_W-1:0] ch, input logic released);
		int row;
		int fill;
		int spot;
		if (released)
			return;
		row = pred_row;
		if (ch == KEY_NEWLINE) begin
			advance_row();
		end else if (ch == KEY_BACKSPACE) begin
			fill = (pred_fill[row] > COLS) ? COLS : pred_fill[row];
			if (fill > 0) begin
				fill = fill - 1;
				pred_fill[row] = fill[6:0];
				queue_update(KIND_CELL, row * COLS + fill, BLANK_CHAR, pred_attr, 0);
			end else if (row > 0) begin
				// empty row: step back to the end of the row above, no erase
				pred_row = 5'(row - 1);
			end
		end else begin
			// full row wraps first, bottom row included
			if (pred_fill[row] >= COLS) begin
				advance_row();
				row = pred_row;
			end
			queue_update(KIND_CELL, row * COLS + pred_fill[row], ch, pred_attr, 0);
			pred_fill[row] = pred_fill[row] + 1'b1;
		end
		spot = pred_row * COLS + pred_fill[pred_row];
		spot = (spot == 0) ? 0 : spot - 1;
		queue_update(KIND_CURSOR, 0, '0, '0, spot);
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t MISMATCH %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report($sformatf("%s: got %0d, want %0d", name, got, want));
	endtask

	// Inputs are predicted when accepted; outputs are popped in order.
	// A result never follows its own key within the same edge.
	always @(posedge clk) begin : scoreboard
		screen_update_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				apply_key(key_char, key_released);
			if (out_valid && out_ready) begin
				if (updates_due.size() == 0) begin
					report($sformatf("result item with nothing pending (kind %0d)",
						result_kind));
				end else begin
					want = updates_due.pop_front();
					check_field("result_kind", result_kind, want.kind);
					check_field("cell_index", cell_index, want.cell_index);
					check_field("cell_char", cell_char, want.cell_char);
					check_field("cell_attr", cell_attr, want.cell_attr);
					check_field("cursor_pos", cursor_pos, want.cursor_pos);
					check_field("last_of_run", last_of_run, want.last);
				end
			end
		end
	end

	// Watchdog: any handshake or bus access resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random ready pattern in phases of its own, plus a long
	// hold-off on request. Phases at 100% give stall-free stretches.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				case ($urandom_range(0, 2))
					0: ready_pct = 100;
					1: ready_pct = 75;
					default: ready_pct = 35;
				endcase
				pattern_left = $urandom_range(20, 80);
			end
			pattern_left--;
			out_ready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender and bus tasks
	// ------------------------------------------------------------------

	// Valid stays up across a burst; the payload changes only after the
	// item went through. A burst end drops valid for a random gap.
	task automatic send_key(input logic [CHAR_W-1:0] ch, input logic released);
		@(negedge clk);
		in_valid     <= 1'b1;
		key_char     <= ch;
		key_released <= released;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 6);
		end
	endtask

	// Stop sending, wait for every pending result, then let the pipe settle
	// (release items leave nothing to wait for).
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (updates_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_TEXT_ATTR)
			pred_attr = data[ATTR_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_check_attr();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_TEXT_ATTR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("text_attribute readback", prdata[ATTR_W-1:0], pred_attr);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] random_printable();
		logic [CHAR_W-1:0] c;
		do
			c = CHAR_W'($urandom_range(0, 255));
		while (c == KEY_NEWLINE || c == KEY_BACKSPACE);
		return c;
	endfunction

	// Mostly printables, with newlines, backspaces and some releases.
	task automatic send_random_key();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			send_key(CHAR_W'($urandom_range(0, 255)), 1'b1);
		else if (pick < 22)
			send_key(KEY_NEWLINE, 1'b0);
		else if (pick < 42)
			send_key(KEY_BACKSPACE, 1'b0);
		else
			send_key(CHAR_W'($urandom_range(0, 255)), 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_attribute_reset();
		apb_check_attr();
	endtask

	// Releases of every kind of key: nothing comes out, nothing moves.
	task automatic test_releases_ignored();
		send_key("A", 1'b1);
		send_key(KEY_NEWLINE, 1'b1);
		send_key(KEY_BACKSPACE, 1'b1);
		send_key(8'hFF, 1'b1);
		drain();
	endtask

	// Backspace on the empty top row: cursor item only, state unchanged.
	task automatic test_backspace_top_empty();
		send_key(KEY_BACKSPACE, 1'b0);
		send_key(KEY_BACKSPACE, 1'b0);
		drain();
	endtask

	// Extreme and neighbouring codes, erase, newline, and the step back
	// from an empty row to the end of the row above.
	task automatic test_basic_editing();
		send_key(8'h00, 1'b0);
		send_key(8'hFF, 1'b0);
		send_key(8'h07, 1'b0);
		send_key(8'h09, 1'b0);
		send_key(8'h0B, 1'b0);
		send_key(BLANK_CHAR, 1'b0);
		send_key(KEY_BACKSPACE, 1'b0);
		send_key(KEY_BACKSPACE, 1'b0);
		send_key(KEY_NEWLINE, 1'b0);
		send_key(KEY_BACKSPACE, 1'b0);   // empty row 1: back to row 0
		send_key("z", 1'b0);
		send_key(KEY_NEWLINE, 1'b0);
		send_key(KEY_NEWLINE, 1'b0);
		drain();
	endtask

	// Type past the end of a row so it wraps, then erase a little.
	task automatic test_row_wrap();
		int n;
		n = COLS + $urandom_range(1, 6);
		repeat (n) send_key(random_printable(), 1'b0);
		repeat (3) send_key(KEY_BACKSPACE, 1'b0);
		drain();
	endtask

	// Run down to the bottom row, newline there, fill it and wrap in
	// place, then walk back up over empty rows.
	task automatic test_bottom_row();
		repeat (NROWS + 1) send_key(KEY_NEWLINE, 1'b0);
		repeat (COLS) send_key(random_printable(), 1'b0);
		send_key(random_printable(), 1'b0);   // wraps on the last row
		send_key(KEY_NEWLINE, 1'b0);
		repeat (4) send_key(KEY_BACKSPACE, 1'b0);
		drain();
	endtask

	// Receiver holds off for a long stretch while keys keep coming, so
	// both stages fill and the input stalls.
	task automatic test_output_backpressure();
		hold_request = HOLD_OFF_CYCLES;
		repeat (16) send_key(random_printable(), 1'b0);
		drain();
	endtask

	// Random keys with occasional typing runs long enough to wrap rows.
	task automatic test_random_mix(input int count);
		int sent;
		int run;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 19) == 0) begin
				run = $urandom_range(10, COLS + 5);
				repeat (run) send_key(random_printable(), 1'b0);
				sent += run;
			end else begin
				send_random_key();
				sent++;
			end
		end
		drain();
	endtask

	task automatic test_attribute_settings();
		apb_write(ADDR_TEXT_ATTR, 32'h0000_0000);
		apb_check_attr();
		test_random_mix(110);
		apb_write(ADDR_TEXT_ATTR, 32'h0000_00FF);
		apb_check_attr();
		test_random_mix(110);
		// the spare address must leave the attribute alone
		apb_write(ADDR_UNUSED, $urandom());
		apb_write(ADDR_TEXT_ATTR, $urandom());
		apb_check_attr();
		test_random_mix(110);
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		key_char     = '0;
		key_released = 1'b0;
		out_ready    = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		hold_request   = 0;
		hold_left      = 0;
		ready_pct      = 100;
		pattern_left   = 0;
		burst_left     = $urandom_range(1, 8);
		pred_row       = '0;
		pred_attr      = ATTR_RESET;
		foreach (pred_fill[i])
			pred_fill[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_attribute_reset();
		test_releases_ignored();
		test_backspace_top_empty();
		test_basic_editing();
		test_row_wrap();
		test_bottom_row();
		test_output_backpressure();
		test_attribute_settings();

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
